### sv/aht_pkg.sv
// Shared types and fixed constants for the allocation tracker hash table.
// No dependencies; every other file of the block except aht_ram refers to this package.
package aht_pkg;

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int IDX_W   = 12;
  localparam int LIMIT_W = 13;
  localparam int DIGIT_W = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4095;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RESIZE  = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SEARCH,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] old_address;
    logic [SIZE_W-1:0] block_size;
    logic [IDX_W-1:0]  slot_index;
  } aht_in_t;

  typedef struct packed {
    logic              found;
    logic              stored;
    logic              entry_valid;
    logic [ADDR_W-1:0] entry_address;
    logic [SIZE_W-1:0] entry_size;
  } aht_out_t;

endpackage

### sv/aht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No package dependencies.
module aht_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/aht_mod.sv
// Home slot unit: address modulo the table depth, one hex digit per cycle, or the low bits for a power of two.
// Depends on aht_pkg for the address and digit widths.
module aht_mod #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [aht_pkg::ADDR_W-1:0]     value,
  output logic                           done,
  output logic [$clog2(TABLE_DEPTH)-1:0] home
);

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int STEPS = aht_pkg::ADDR_W / aht_pkg::DIGIT_W;
  localparam int SW    = $clog2(STEPS + 1);
  localparam logic [IW:0] DEPTH_C = (IW + 1)'(TABLE_DEPTH);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [SW-1:0]              cnt_r, cnt_nxt;
  logic [aht_pkg::ADDR_W-1:0] sh_r, sh_nxt;
  logic [IW-1:0]              rem_r, rem_nxt;
  logic [IW-1:0]              step_rem;

  // Shift in one bit at a time and keep the remainder below the depth.
  always_comb begin
    logic [IW:0]   t;
    logic [IW-1:0] r;
    r = rem_r;
    for (int k = 0; k < aht_pkg::DIGIT_W; k++) begin
      t = {r, sh_r[aht_pkg::ADDR_W-1-k]};
      if (t >= DEPTH_C) begin
        t = t - DEPTH_C;
      end
      r = t[IW-1:0];
    end
    step_rem = r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      if (IS_POW2) begin
        rem_nxt  = value[IW-1:0];
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        sh_nxt   = value;
        rem_nxt  = '0;
        cnt_nxt  = '0;
      end
    end else if (busy_r) begin
      rem_nxt = step_rem;
      sh_nxt  = sh_r << aht_pkg::DIGIT_W;
      cnt_nxt = cnt_r + SW'(1);
      if (cnt_r == SW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign home = rem_r;

endmodule

### sv/allocation_tracker_hash_table_core.sv
// Allocation tracker: open-addressed table of live allocations with linear probing.
// Depends on aht_pkg, aht_mod (home slot) and aht_ram (address and size memories).
//
// After reset the block clears every slot of the address memory and accepts no
// request in that time; configuration writes are taken at any time.
// One request is in work at a time. The home slot is the low address bits when
// TABLE_DEPTH is a power of two and is otherwise reduced one hex digit at a time.
// The search then reads one slot per cycle from the address memory, probing up to
// the first empty slot for allocate and up to the match or release limit for release.
// A resize is a release followed by an allocate. A read slot request reads its
// slot in ST_READ and then passes through ST_DONE. A finished result sits in an
// output register, so the next request is taken while it waits.
module allocation_tracker_hash_table_core #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  aht_pkg::aht_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output aht_pkg::aht_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [aht_pkg::LIMIT_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = IW + 1;

  aht_pkg::state_t            state_r, state_nxt;
  logic [aht_pkg::LIMIT_W-1:0] limit_r;
  logic [1:0]                 req_r, req_nxt;
  logic [aht_pkg::ADDR_W-1:0] key_r, key_nxt;
  logic [aht_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [aht_pkg::SIZE_W-1:0] bytes_r, bytes_nxt;
  logic                       sto_r, sto_nxt;
  logic                       rd_ok_r, rd_ok_nxt;
  logic [IW-1:0]              s_r, s_nxt;
  logic [IW-1:0]              chk_s_r, chk_s_nxt;
  logic [CW-1:0]              iss_r, iss_nxt;
  logic                       pend_r, pend_nxt;
  logic                       pend_last_r, pend_last_nxt;
  logic [IW-1:0]              clr_r, clr_nxt;
  aht_pkg::aht_out_t          res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  aht_pkg::aht_out_t          out_data_r, out_data_nxt;

  logic                       mod_start;
  logic [aht_pkg::ADDR_W-1:0] mod_value;
  logic                       mod_done;
  logic [IW-1:0]              mod_home;

  logic                       addr_we;
  logic [IW-1:0]              addr_waddr;
  logic [aht_pkg::ADDR_W-1:0] addr_wdata;
  logic                       bytes_we;
  logic [IW-1:0]              ram_raddr;
  logic [aht_pkg::ADDR_W-1:0] addr_rdata;
  logic [aht_pkg::SIZE_W-1:0] bytes_rdata;

  logic [31:0]                idx_wide;
  logic [31:0]                lim_wide;
  logic [CW-1:0]              rel_lim;
  logic [CW-1:0]              cur_lim;
  logic                       hit;
  logic                       finish;

  aht_mod #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .home  (mod_home)
  );

  aht_ram #(.WIDTH(aht_pkg::ADDR_W), .DEPTH(TABLE_DEPTH)) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (addr_waddr),
    .wdata (addr_wdata),
    .raddr (ram_raddr),
    .rdata (addr_rdata)
  );

  aht_ram #(.WIDTH(aht_pkg::SIZE_W), .DEPTH(TABLE_DEPTH)) u_bytes_ram (
    .clk   (clk),
    .we    (bytes_we),
    .waddr (chk_s_r),
    .wdata (bytes_r),
    .raddr (ram_raddr),
    .rdata (bytes_rdata)
  );

  // A release limit of zero acts as one, and one above the depth acts as the depth.
  always_comb begin
    if (limit_r == '0) begin
      lim_wide = 32'd1;
    end else if (32'(limit_r) > 32'(TABLE_DEPTH)) begin
      lim_wide = 32'(TABLE_DEPTH);
    end else begin
      lim_wide = 32'(limit_r);
    end
  end

  assign rel_lim  = lim_wide[CW-1:0];
  assign cur_lim  = sto_r ? CW'(TABLE_DEPTH) : rel_lim;
  assign idx_wide = 32'(in_data.slot_index);
  assign hit      = pend_r && (sto_r ? (addr_rdata == '0) : (addr_rdata == key_r));
  assign finish   = hit || (pend_r && pend_last_r);

  assign in_stall = (state_r != aht_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    bytes_nxt     = bytes_r;
    sto_nxt       = sto_r;
    rd_ok_nxt     = rd_ok_r;
    s_nxt         = s_r;
    chk_s_nxt     = chk_s_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mod_start     = 1'b0;
    mod_value     = in_data.address;
    addr_we       = 1'b0;
    addr_waddr    = chk_s_r;
    addr_wdata    = '0;
    bytes_we      = 1'b0;
    ram_raddr     = s_r;

    case (state_r)
      aht_pkg::ST_CLEAR: begin
        addr_we    = 1'b1;
        addr_waddr = clr_r;
        clr_nxt    = clr_r + IW'(1);
        if (clr_r == IW'(TABLE_DEPTH - 1)) begin
          state_nxt = aht_pkg::ST_IDLE;
        end
      end

      aht_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data.req_type;
          addr_nxt  = in_data.address;
          bytes_nxt = in_data.block_size;
          res_nxt   = '0;
          case (in_data.req_type)
            aht_pkg::REQ_READ: begin
              ram_raddr = idx_wide[IW-1:0];
              rd_ok_nxt = idx_wide < 32'(TABLE_DEPTH);
              state_nxt = aht_pkg::ST_READ;
            end
            aht_pkg::REQ_RESIZE: begin
              if (in_data.old_address != '0) begin
                mod_start = 1'b1;
                mod_value = in_data.old_address;
                key_nxt   = in_data.old_address;
                sto_nxt   = 1'b0;
                state_nxt = aht_pkg::ST_HASH;
              end else if (in_data.address != '0) begin
                mod_start = 1'b1;
                key_nxt   = in_data.address;
                sto_nxt   = 1'b1;
                state_nxt = aht_pkg::ST_HASH;
              end else begin
                state_nxt = aht_pkg::ST_DONE;
              end
            end
            default: begin
              // Allocate or release of a single address.
              if (in_data.address != '0) begin
                mod_start = 1'b1;
                key_nxt   = in_data.address;
                sto_nxt   = (in_data.req_type == aht_pkg::REQ_ALLOC);
                state_nxt = aht_pkg::ST_HASH;
              end else begin
                state_nxt = aht_pkg::ST_DONE;
              end
            end
          endcase
        end
      end

      aht_pkg::ST_HASH: begin
        if (mod_done) begin
          s_nxt     = mod_home;
          iss_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = aht_pkg::ST_SEARCH;
        end
      end

      aht_pkg::ST_SEARCH: begin
        // A read goes out each cycle while the previous slot is checked;
        // the read after a hit is simply dropped.
        if (finish) begin
          pend_nxt = 1'b0;
          if (hit) begin
            addr_we    = 1'b1;
            addr_wdata = sto_r ? key_r : '0;
            bytes_we   = sto_r;
            if (sto_r) begin
              res_nxt.stored = 1'b1;
            end else begin
              res_nxt.found = 1'b1;
            end
          end
          if (!sto_r && req_r == aht_pkg::REQ_RESIZE && addr_r != '0) begin
            mod_start = 1'b1;
            mod_value = addr_r;
            key_nxt   = addr_r;
            sto_nxt   = 1'b1;
            state_nxt = aht_pkg::ST_HASH;
          end else begin
            state_nxt = aht_pkg::ST_DONE;
          end
        end else begin
          ram_raddr     = s_r;
          pend_nxt      = 1'b1;
          pend_last_nxt = (iss_r + CW'(1)) == cur_lim;
          chk_s_nxt     = s_r;
          s_nxt         = (s_r == IW'(TABLE_DEPTH - 1)) ? '0 : s_r + IW'(1);
          iss_nxt       = iss_r + CW'(1);
        end
      end

      aht_pkg::ST_READ: begin
        if (rd_ok_r && addr_rdata != '0) begin
          res_nxt.entry_valid   = 1'b1;
          res_nxt.entry_address = addr_rdata;
          res_nxt.entry_size    = bytes_rdata;
        end
        state_nxt = aht_pkg::ST_DONE;
      end

      aht_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = aht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = aht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aht_pkg::ST_CLEAR;
      limit_r     <= aht_pkg::LIMIT_RESET;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
    req_r       <= req_nxt;
    key_r       <= key_nxt;
    addr_r      <= addr_nxt;
    bytes_r     <= bytes_nxt;
    sto_r       <= sto_nxt;
    rd_ok_r     <= rd_ok_nxt;
    s_r         <= s_nxt;
    chk_s_r     <= chk_s_nxt;
    iss_r       <= iss_nxt;
    pend_last_r <= pend_last_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/aht_chk.sv
// Port-level checker for the allocation tracker core, attached by bind.
// Depends on aht_pkg for the result payload type.
module aht_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input aht_pkg::aht_out_t out_data
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // One request at a time: a transfer in closes the input until it is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.entry_valid |->
      out_data.entry_address == '0 && out_data.entry_size == '0)
    else $error("entry fields set without a live entry");

  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.entry_valid |->
      !out_data.found && !out_data.stored && out_data.entry_address != '0)
    else $error("read slot result mixed with table update flags");

endmodule

bind allocation_tracker_hash_table_core aht_chk u_aht_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/allocation_tracker_hash_table_core_tb.sv
// Self-checking testbench for allocation_tracker_hash_table_core: directed, random
// and backpressure tests against a predictor of the probing table.
// Depends on aht_pkg and the RTL of the block only.
module allocation_tracker_hash_table_core_tb;

  localparam int TBL_DEPTH    = 4096;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 2 * TBL_DEPTH + 64;
  localparam int MAX_REPORTS  = 100;
  localparam int LIVE_CAP     = 56;

  localparam logic [aht_pkg::LIMIT_W-1:0] LIMIT_FULL = 13'd4096;
  localparam logic [aht_pkg::LIMIT_W-1:0] LIMIT_MAX  = 13'd8191;

  localparam logic [aht_pkg::ADDR_W-1:0] ADDR_TOP  = '1;
  localparam logic [aht_pkg::ADDR_W-1:0] ADDR_WRAP = 48'h5A5A_0000_0FFF;
  localparam logic [aht_pkg::ADDR_W-1:0] ADDR_MOVE = 48'h0123_4567_8005;
  localparam logic [aht_pkg::ADDR_W-1:0] ADDR_TWIN = 48'h00C0_FFEE_0064;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  aht_pkg::aht_in_t            in_data;
  logic                        out_valid;
  logic                        out_stall;
  aht_pkg::aht_out_t           out_data;
  logic                        cfg_we;
  logic [aht_pkg::LIMIT_W-1:0] cfg_wdata;

  allocation_tracker_hash_table_core #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted table contents and register.
  logic [aht_pkg::ADDR_W-1:0]  tbl_addr  [TBL_DEPTH];
  logic [aht_pkg::SIZE_W-1:0]  tbl_bytes [TBL_DEPTH];
  logic [aht_pkg::LIMIT_W-1:0] probe_lim;
  logic [aht_pkg::ADDR_W-1:0]  live_q [$];
  aht_pkg::aht_out_t           pending_outcomes [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int req_count [4]  = '{0, 0, 0, 0};
  int outcomes_checked = 0;
  int errors      = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int effective_limit();
    int e;
    e = int'(probe_lim);
    if (e == 0) e = 1;
    if (e > TBL_DEPTH) e = TBL_DEPTH;
    return e;
  endfunction

  // The depth is 2**IDX_W, so the home slot is the low address bits and the
  // slot counter wraps by itself.
  function automatic logic tbl_insert(input logic [aht_pkg::ADDR_W-1:0] a,
                                      input logic [aht_pkg::SIZE_W-1:0] b);
    logic [aht_pkg::IDX_W-1:0] s;
    if (a == '0) return 1'b0;
    s = a[aht_pkg::IDX_W-1:0];
    for (int n = 0; n < TBL_DEPTH; n++) begin
      if (tbl_addr[s] == '0) begin
        tbl_addr[s]  = a;
        tbl_bytes[s] = b;
        live_q.push_back(a);
        return 1'b1;
      end
      s = s + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic tbl_remove(input logic [aht_pkg::ADDR_W-1:0] a);
    logic [aht_pkg::IDX_W-1:0] s;
    int lim;
    if (a == '0) return 1'b0;
    lim = effective_limit();
    s = a[aht_pkg::IDX_W-1:0];
    for (int n = 0; n < lim; n++) begin
      if (tbl_addr[s] == a) begin
        tbl_addr[s] = '0;
        for (int i = 0; i < live_q.size(); i++) begin
          if (live_q[i] == a) begin
            live_q.delete(i);
            break;
          end
        end
        return 1'b1;
      end
      s = s + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic aht_pkg::aht_out_t predict_outcome(input aht_pkg::aht_in_t rq);
    aht_pkg::aht_out_t r;
    r = '0;
    case (rq.req_type)
      aht_pkg::REQ_ALLOC: begin
        r.stored = tbl_insert(rq.address, rq.block_size);
      end
      aht_pkg::REQ_RELEASE: begin
        r.found = tbl_remove(rq.address);
      end
      aht_pkg::REQ_RESIZE: begin
        r.found  = tbl_remove(rq.old_address);
        r.stored = tbl_insert(rq.address, rq.block_size);
      end
      default: begin
        if (tbl_addr[rq.slot_index] != '0) begin
          r.entry_valid   = 1'b1;
          r.entry_address = tbl_addr[rq.slot_index];
          r.entry_size    = tbl_bytes[rq.slot_index];
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [aht_pkg::ADDR_W-1:0] rand_addr48();
    logic [31:0] lo;
    lo = $urandom();
    return {$urandom(), lo[15:0]};
  endfunction

  // Addresses whose home slots sit in a 64-slot window across the wrap point,
  // so that chains collide and run past the last slot.
  function automatic logic [aht_pkg::ADDR_W-1:0] window_address();
    logic [aht_pkg::ADDR_W-1:0] a;
    logic [31:0] rnd;
    rnd = $urandom();
    a[47:16] = $urandom();
    a[15:12] = rnd[3:0];
    a[11:0]  = 12'd4064 + {6'd0, rnd[9:4]};
    return a;
  endfunction

  function automatic aht_pkg::aht_in_t scrambled_request(input logic [1:0] t);
    aht_pkg::aht_in_t rq;
    logic [31:0] rnd;
    rnd = $urandom();
    rq.req_type    = t;
    rq.address     = window_address();
    rq.old_address = rand_addr48();
    rq.block_size  = $urandom();
    rq.slot_index  = rnd[aht_pkg::IDX_W-1:0];
    return rq;
  endfunction

  function automatic aht_pkg::aht_in_t random_request();
    aht_pkg::aht_in_t rq;
    int r;
    int live;
    int miss_pct;
    logic [31:0] rnd;
    rnd = $urandom();
    rq = scrambled_request(aht_pkg::REQ_READ);
    r = $urandom_range(0, 99);
    live = live_q.size();
    // A missed search walks the whole limit, so misses stay rare when it is large.
    miss_pct = (effective_limit() > 64) ? 3 : 25;
    if ((live < 8 && r < 55) || (live < LIVE_CAP && r < 30)) begin
      rq.req_type = aht_pkg::REQ_ALLOC;
      if (chance(4)) rq.address = '0;
      else if (chance(6)) rq.address = rand_addr48();
    end else if (r < 55 || (live >= LIVE_CAP && r < 75)) begin
      rq.req_type = aht_pkg::REQ_RELEASE;
      if (chance(3)) rq.address = '0;
      else if (live > 0 && !chance(miss_pct))
        rq.address = live_q[$urandom_range(0, live - 1)];
    end else if (r < 75) begin
      rq.req_type = aht_pkg::REQ_RESIZE;
      if (chance(5)) rq.old_address = '0;
      else if (live > 0 && !chance(miss_pct))
        rq.old_address = live_q[$urandom_range(0, live - 1)];
      else rq.old_address = window_address();
      if (chance(5)) rq.address = '0;
    end else begin
      if (chance(70)) rq.slot_index = 12'd4064 + {6'd0, rnd[17:12]};
    end
    return rq;
  endfunction

  // Valid stays high from one transfer to the next unless a gap is drawn.
  task automatic send_item(input aht_pkg::aht_in_t rq);
    while (chance(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(predict_outcome(rq));
    req_count[rq.req_type]++;
  endtask

  task automatic send_alloc(input logic [aht_pkg::ADDR_W-1:0] a,
                            input logic [aht_pkg::SIZE_W-1:0] b);
    aht_pkg::aht_in_t rq;
    rq = scrambled_request(aht_pkg::REQ_ALLOC);
    rq.address    = a;
    rq.block_size = b;
    send_item(rq);
  endtask

  task automatic send_release(input logic [aht_pkg::ADDR_W-1:0] a);
    aht_pkg::aht_in_t rq;
    rq = scrambled_request(aht_pkg::REQ_RELEASE);
    rq.address = a;
    send_item(rq);
  endtask

  task automatic send_resize(input logic [aht_pkg::ADDR_W-1:0] old,
                             input logic [aht_pkg::ADDR_W-1:0] a,
                             input logic [aht_pkg::SIZE_W-1:0] b);
    aht_pkg::aht_in_t rq;
    rq = scrambled_request(aht_pkg::REQ_RESIZE);
    rq.old_address = old;
    rq.address     = a;
    rq.block_size  = b;
    send_item(rq);
  endtask

  task automatic send_read(input logic [aht_pkg::IDX_W-1:0] idx);
    aht_pkg::aht_in_t rq;
    rq = scrambled_request(aht_pkg::REQ_READ);
    rq.slot_index = idx;
    send_item(rq);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [aht_pkg::LIMIT_W-1:0] v);
    quiesce();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    probe_lim = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic purge_table();
    set_limit(LIMIT_FULL);
    while (live_q.size() != 0) send_release(live_q[0]);
  endtask

  task automatic test_edge_requests();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_alloc('0, '1);
    send_release('0);
    send_resize('0, '0, $urandom());
    send_alloc(ADDR_TOP, '1);
    send_alloc(ADDR_WRAP, '0);
    send_read(12'hFFF);
    send_read(12'h000);
    send_read(12'h001);
    send_resize('0, ADDR_MOVE, $urandom());
    send_resize(ADDR_MOVE, '0, $urandom());
    // A zero limit acts as one, so only the home slot is searched.
    set_limit('0);
    send_release(ADDR_WRAP);
    set_limit(13'd1);
    send_release(ADDR_WRAP);
    set_limit(13'd2);
    send_release(ADDR_WRAP);
    send_release(ADDR_TOP);
    send_release(ADDR_TOP);
    send_alloc(ADDR_TWIN, 32'h1234_5678);
    send_alloc(ADDR_TWIN, 32'h8765_4321);
    send_read(12'd101);
    send_release(ADDR_TWIN);
    send_read(12'd100);
    send_release(ADDR_TWIN);
  endtask

  task automatic run_random_phase(input int n, input int s_pct, input int r_pct,
                                  input logic [aht_pkg::LIMIT_W-1:0] lim);
    purge_table();
    set_limit(lim);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) send_item(random_request());
  endtask

  task automatic test_random_traffic();
    run_random_phase(360, 0, 0, 13'd4095);
    run_random_phase(360, 85, 0, 13'd3);
    run_random_phase(360, 0, 85, LIMIT_MAX);
    run_random_phase(360, 33, 33, 13'd16);
  endtask

  task automatic test_backpressure();
    quiesce();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // The receiver holds off while the sender keeps offering, so the input stalls.
    hold_reqs++;
    repeat (24) send_item(random_request());
    quiesce();
    repeat (12) send_item(random_request());
  endtask

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= chance(recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_outcomes
    aht_pkg::aht_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result transfer: expected none", $time);
          $display("%0t:           actual found=%0b stored=%0b valid=%0b addr=%h size=%h",
                   $time, out_data.found, out_data.stored, out_data.entry_valid,
                   out_data.entry_address, out_data.entry_size);
        end
      end else begin
        want = pending_outcomes.pop_front();
        outcomes_checked++;
        if (out_data !== want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: mismatch: expected found=%0b stored=%0b valid=%0b addr=%h size=%h",
                     $time, want.found, want.stored, want.entry_valid,
                     want.entry_address, want.entry_size);
            $display("%0t:           actual found=%0b stored=%0b valid=%0b addr=%h size=%h",
                     $time, out_data.found, out_data.stored, out_data.entry_valid,
                     out_data.entry_address, out_data.entry_size);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** allocation_tracker_hash_table_core: FAILED **");
    $finish;
  end

  initial begin : run_tests
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl_addr[i]  = '0;
      tbl_bytes[i] = '0;
    end
    probe_lim = aht_pkg::LIMIT_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_requests();
    test_random_traffic();
    test_backpressure();

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d allocate, %0d release, %0d resize and %0d read slot requests.",
             req_count[aht_pkg::REQ_ALLOC], req_count[aht_pkg::REQ_RELEASE],
             req_count[aht_pkg::REQ_RESIZE], req_count[aht_pkg::REQ_READ]);
    $display("Checked %0d results over null, wrap, probe-limit and stall mixes; %0d failures.",
             outcomes_checked, errors);
    if (errors == 0) begin
      $display("** allocation_tracker_hash_table_core: PASSED **");
    end else begin
      $display("** allocation_tracker_hash_table_core: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
sv/aht_pkg.sv
sv/aht_ram.sv
sv/aht_mod.sv
sv/allocation_tracker_hash_table_core.sv
sv/aht_chk.sv
tb/allocation_tracker_hash_table_core_tb.sv
